>>> hw/rtl/bpa_pkg.sv
package bpa_pkg;

	localparam int CMD_W = 2;
	localparam int IDX_W = 12;
	localparam int ST_W  = 2;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [IDX_W-1:0] page_idx_t;
	typedef logic [ST_W-1:0]  status_t;

	localparam cmd_t CMD_ALLOC   = 2'd0;
	localparam cmd_t CMD_DEALLOC = 2'd1;
	localparam cmd_t CMD_QUERY   = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_RANGE = 2'd2;
	localparam status_t ST_FREE  = 2'd3;

endpackage

>>> hw/rtl/bpa_if.sv
// Request channel: one word carries a command and a page index.
interface bpa_req_if;
	logic               valid;
	logic               ready;
	bpa_pkg::cmd_t      cmd;
	bpa_pkg::page_idx_t page_index;

	modport source (output valid, output cmd, output page_index, input ready);
	modport sink   (input valid, input cmd, input page_index, output ready);
endinterface

// Response channel: one word per request.
interface bpa_rsp_if;
	logic               valid;
	logic               ready;
	bpa_pkg::status_t   status;
	bpa_pkg::page_idx_t alloc_index;
	logic               page_free;

	modport source (output valid, output status, output alloc_index, output page_free,
		input ready);
	modport sink   (input valid, input status, input alloc_index, input page_free,
		output ready);
endinterface

>>> hw/rtl/bpa_map.sv
// Bitmap storage: one write port, one registered read port. A row that was
// never written since reset reads as all zeros through its valid bit.
module bpa_map #(
	parameter int NUM_WORDS = 128,
	parameter int WORD_BITS = 32,
	parameter int WIDX      = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [WIDX-1:0]      rd_addr,
	output logic [WORD_BITS-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [WIDX-1:0]      wr_addr,
	input  logic [WORD_BITS-1:0] wr_data
);

	logic [WORD_BITS-1:0] mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] row_vld_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic                 rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rvld_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			rvld_q <= row_vld_q[rd_addr];
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

>>> hw/rtl/bpa_ffz.sv
// Finds the lowest clear bit of a word (a clear bit is a free page).
module bpa_ffz #(
	parameter int WORD_BITS = 32,
	parameter int BW        = 5
) (
	input  logic [WORD_BITS-1:0] word,
	output logic                 found,
	output logic [BW-1:0]        idx
);

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				found = 1'b1;
				idx   = BW'(i);
			end
		end
	end

endmodule

>>> hw/rtl/bitmap_page_allocator_unit.sv
// Channel | Direction | Contents of one word
// --------+-----------+--------------------------------------------------
// req     | in        | cmd (2b: allocate, deallocate, query), page_index (12b)
// rsp     | out       | status (2b), alloc_index (12b), page_free (1b)
//
// Deallocate and query pass through the decode, split, check and response states.
// Allocate passes through decode and grant write; if the granted page's word has
// no free bit left, it scans the following words until one has or the last is read.
// A refused request or an unused command code goes from decode to response.
// The single read port of the bitmap memory, one word per cycle, paces the scan.
// Reset clears per-row valid bits at once, so no clearing pass is needed.
// req is ready only while the sequencer is idle; a pending response does not
// block the next request, the sequencer waits only if a second one is due.
module bitmap_page_allocator_unit #(
	parameter int NUM_PAGES = 4096,
	parameter int WORD_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	bpa_req_if.sink  req,
	bpa_rsp_if.source rsp
);

	import bpa_pkg::*;

	// Geometry of the bitmap.
	localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int PW        = $clog2(NUM_PAGES + 1);
	localparam int LAST_W    = NUM_WORDS - 1;
	localparam int LAST_BITS = NUM_PAGES - LAST_W * WORD_BITS;

	// Bits past the last page in the final word are treated as in use.
	localparam logic [WORD_BITS-1:0] PAD_MASK = (LAST_BITS == WORD_BITS) ? '0 :
		~((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));

	// Reciprocal used to split a 12-bit page index into word and bit. With the
	// shift at index width plus ceil(log2(WORD_BITS)) the quotient is exact.
	localparam int SH    = IDX_W + BW;
	localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SPLIT  = 3'd2;
	localparam logic [2:0] S_CHK    = 3'd3;
	localparam logic [2:0] S_AWR    = 3'd4;
	localparam logic [2:0] S_SCAN   = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	logic [2:0]      state_q;
	cmd_t            cmd_q;
	page_idx_t       idx_q;

	// Lowest free page, kept both as a page number and as word, bit and base.
	logic [PW-1:0]   lf_page_q;
	logic [PW-1:0]   lf_base_q;
	logic [WIDX-1:0] lf_w_q;
	logic [BW-1:0]   lf_b_q;
	logic [PW-1:0]   used_q;

	// Index split for deallocate and query.
	logic [WIDX-1:0] qw_q;
	logic [BW-1:0]   rb_q;
	logic [PW-1:0]   qbase_q;

	// Scan position.
	logic [WIDX-1:0] scan_w_q;
	logic [PW-1:0]   scan_base_q;

	// Pending result and the output register.
	status_t         res_status_q;
	page_idx_t       res_idx_q;
	logic            res_free_q;
	logic            out_valid_q;
	status_t         out_status_q;
	page_idx_t       out_idx_q;
	logic            out_free_q;
	logic            load_out;

	// Memory and search unit hookup.
	logic [WIDX-1:0]      rd_addr;
	logic [WORD_BITS-1:0] rword;
	logic                 wr_en;
	logic [WIDX-1:0]      wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [WORD_BITS-1:0] merged;
	logic [WORD_BITS-1:0] ffz_word;
	logic                 chk_last;
	logic                 ffz_found;
	logic [BW-1:0]        ffz_idx;

	logic                 idx_oob;
	logic                 map_full;
	logic [IDX_W+16-1:0]  quot_prod;

	assign idx_oob   = 32'(idx_q) >= NUM_PAGES;
	assign map_full  = (32'(used_q) >= NUM_PAGES) || (32'(lf_page_q) >= NUM_PAGES);
	assign quot_prod = (IDX_W + 16)'(idx_q) * (IDX_W + 16)'(RECIP);
	assign merged    = rword | (WORD_BITS'(1) << lf_b_q);

	// The result moves into the output register once that register is free.
	assign load_out  = (state_q == S_RESP) && (!out_valid_q || rsp.ready);

	// The search unit looks at the freshly merged word right after the grant,
	// and at the word just read while scanning.
	assign chk_last = (state_q == S_AWR) ? (32'(lf_w_q) == LAST_W) : (32'(scan_w_q) == LAST_W);
	assign ffz_word = ((state_q == S_AWR) ? merged : rword) | (chk_last ? PAD_MASK : '0);

	always_comb begin
		rd_addr = lf_w_q;
		wr_en   = 1'b0;
		wr_addr = lf_w_q;
		wr_data = merged;
		case (state_q)
			S_SPLIT: rd_addr = qw_q;
			S_AWR: begin
				rd_addr = WIDX'(lf_w_q + WIDX'(1));
				wr_en   = 1'b1;
			end
			S_SCAN:  rd_addr = WIDX'(scan_w_q + WIDX'(1));
			S_CHK: begin
				wr_addr = qw_q;
				wr_data = rword & ~(WORD_BITS'(1) << rb_q);
				wr_en   = (cmd_q == CMD_DEALLOC) && rword[rb_q];
			end
			default: rd_addr = lf_w_q;
		endcase
	end

	bpa_map #(
		.NUM_WORDS(NUM_WORDS),
		.WORD_BITS(WORD_BITS),
		.WIDX     (WIDX)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(rd_addr),
		.rd_data(rword),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	bpa_ffz #(
		.WORD_BITS(WORD_BITS),
		.BW       (BW)
	) u_ffz (
		.word (ffz_word),
		.found(ffz_found),
		.idx  (ffz_idx)
	);

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q <= req.cmd;
			idx_q <= req.page_index;
		end
		if (state_q == S_DECODE) begin
			qw_q <= WIDX'(quot_prod >> SH);
		end
		if (state_q == S_SPLIT) begin
			rb_q    <= BW'(32'(idx_q) - 32'(qw_q) * WORD_BITS);
			qbase_q <= PW'(32'(qw_q) * WORD_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lf_page_q    <= '0;
			lf_base_q    <= '0;
			lf_w_q       <= '0;
			lf_b_q       <= '0;
			used_q       <= '0;
			scan_w_q     <= '0;
			scan_base_q  <= '0;
			res_status_q <= ST_OK;
			res_idx_q    <= '0;
			res_free_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_idx_q    <= '0;
			out_free_q   <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						res_status_q <= ST_OK;
						res_idx_q    <= '0;
						res_free_q   <= 1'b0;
						state_q      <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (cmd_q == CMD_ALLOC) begin
						if (map_full) begin
							res_status_q <= ST_FULL;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_AWR;
						end
					end else if (cmd_q == CMD_DEALLOC || cmd_q == CMD_QUERY) begin
						if (idx_oob) begin
							res_status_q <= ST_RANGE;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_SPLIT;
						end
					end else begin
						state_q <= S_RESP;
					end
				end
				S_SPLIT: state_q <= S_CHK;
				S_CHK: begin
					if (cmd_q == CMD_QUERY) begin
						res_free_q <= !rword[rb_q];
					end else if (!rword[rb_q]) begin
						res_status_q <= ST_FREE;
					end else begin
						if (used_q != '0) begin
							used_q <= used_q - PW'(1);
						end
						if (32'(idx_q) < 32'(lf_page_q)) begin
							lf_page_q <= PW'(idx_q);
							lf_base_q <= qbase_q;
							lf_w_q    <= qw_q;
							lf_b_q    <= rb_q;
						end
					end
					state_q <= S_RESP;
				end
				S_AWR: begin
					// The granted page is marked; look for the next free one.
					res_idx_q <= page_idx_t'(lf_page_q);
					used_q    <= used_q + PW'(1);
					if (ffz_found) begin
						lf_b_q    <= ffz_idx;
						lf_page_q <= lf_base_q + PW'(ffz_idx);
						state_q   <= S_RESP;
					end else if (chk_last) begin
						lf_page_q <= PW'(NUM_PAGES);
						state_q   <= S_RESP;
					end else begin
						scan_w_q    <= WIDX'(lf_w_q + WIDX'(1));
						scan_base_q <= lf_base_q + PW'(WORD_BITS);
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (ffz_found) begin
						lf_w_q    <= scan_w_q;
						lf_b_q    <= ffz_idx;
						lf_base_q <= scan_base_q;
						lf_page_q <= scan_base_q + PW'(ffz_idx);
						state_q   <= S_RESP;
					end else if (chk_last) begin
						lf_page_q <= PW'(NUM_PAGES);
						state_q   <= S_RESP;
					end else begin
						scan_w_q    <= WIDX'(scan_w_q + WIDX'(1));
						scan_base_q <= scan_base_q + PW'(WORD_BITS);
					end
				end
				S_RESP: begin
					// Hand the result over once the output register is free.
					if (load_out) begin
						out_status_q <= res_status_q;
						out_idx_q    <= res_idx_q;
						out_free_q   <= res_free_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.alloc_index = out_idx_q;
	assign rsp.page_free   = out_free_q;

	// The allocation count never exceeds the number of pages.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= NUM_PAGES)
		else $error("used page count exceeds page count");

	// Between requests, a full pointer and a full count agree.
	a_full_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		((32'(lf_page_q) == NUM_PAGES) == (32'(used_q) == NUM_PAGES)))
		else $error("free pointer and used count disagree on a full map");

	// Between requests, the pointer's word base and bit rebuild its page number.
	a_ptr_split: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && 32'(lf_page_q) < NUM_PAGES) |->
		(lf_page_q == lf_base_q + PW'(lf_b_q)))
		else $error("free pointer split is inconsistent");

	// An accepted request always starts decoding in the next cycle.
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_DECODE))
		else $error("accepted request did not enter decode");

	// A result is only moved out while the sequencer finishes a request.
	a_load_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RESP))
		else $error("response appeared outside the response state");

endmodule
